FILE: rtl/core/grib_message_locator_core_macros.svh
// assertion macros for the grib message locator
// expects clk_i and rst_ni in the scope of the module that uses them
`ifndef GRIB_MESSAGE_LOCATOR_CORE_MACROS_SVH
`define GRIB_MESSAGE_LOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define GML_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GML_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gml_pkg.sv
// types and constants of the grib message locator
// no dependencies
`default_nettype none

package gml_pkg;

  localparam int unsigned PosW     = 48;
  localparam int unsigned HdrBytes = 16;
  localparam int unsigned CntW     = 32;
  localparam int unsigned LenW     = 64;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 48;

  localparam logic [CfgIdxW-1:0] CfgDataSize    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxMessages = 2'd1;

  localparam logic [PosW-1:0] PosMax    = {PosW{1'b1}};
  localparam logic [PosW-1:0] MinLen    = PosW'(16);
  localparam logic [PosW-1:0] LastHdrAt = PosW'(HdrBytes - 1);
  localparam logic [CntW-1:0] MaxMsgRst = {CntW{1'b1}};

  localparam logic [7:0] ChG = 8'h47;
  localparam logic [7:0] ChR = 8'h52;
  localparam logic [7:0] ChI = 8'h49;
  localparam logic [7:0] ChB = 8'h42;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChD = 8'h44;
  localparam logic [7:0] ChF = 8'h46;
  localparam logic [7:0] ChM = 8'h4D;
  localparam logic [7:0] Ed1 = 8'd1;
  localparam logic [7:0] Ed2 = 8'd2;

  // query-data magic, first file byte in the top byte
  localparam logic [39:0] QdMagic = 40'h40_24_B0_A3_51;

  typedef enum logic [1:0] {
    KIND_GRIB1     = 2'd0,
    KIND_GRIB2     = 2'd1,
    KIND_NETCDF    = 2'd2,
    KIND_QUERYDATA = 2'd3
  } kind_e;

  typedef struct packed {
    logic            found;
    kind_e           kind;
    logic [PosW-1:0] offset;
    logic            done_res;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/gml_in_if.sv
// byte input channel of the grib message locator
// no dependencies
`default_nettype none

interface gml_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/gml_out_if.sv
// result channel of the grib message locator
// depends on gml_pkg
`default_nettype none

interface gml_out_if
  import gml_pkg::*;
;
  logic            valid;
  logic            ready;
  logic            found;
  logic [1:0]      kind;
  logic [PosW-1:0] offset;
  logic            done_res;

  modport source (output valid, output found, output kind, output offset,
                  output done_res, input ready);
  modport sink (input valid, input found, input kind, input offset,
                input done_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/grib_message_locator_core.sv
// grib message locator: 16-byte window scan, candidate check and result buffer
// depends on gml_pkg, gml_in_if, gml_out_if and the assertion macro header
// the result is registered, into the output or the skid entry, at the edge that accepts its beat
// throughput: one byte per cycle; input stalls only while both output entries are full
// reset: asynchronous, active low; clears window, counters, stop flag and output buffer,
// data_size to zero and max_messages to all ones
`default_nettype none
`include "grib_message_locator_core_macros.svh"

module grib_message_locator_core
  import gml_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  gml_in_if.sink                   in_ch,
  gml_out_if.source                out_ch
);

  logic [7:0]      win_q [HdrBytes];
  logic [7:0]      nw    [HdrBytes];
  logic [PosW-1:0] pos_q, pos_d;
  logic [PosW-1:0] resume_q, resume_d;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc;
  logic            stopped_q, stopped_d;
  logic [PosW-1:0] ds_q;
  logic [CntW-1:0] max_q;

  logic            ov_q, sv_q;
  res_t            od_q, sd_q;

  logic            accept, active, push, pop;
  logic            cdf, fmig, qd, magic_done, cand_en, grib, ed_ok, hit;
  logic [7:0]      ed;
  logic [LenW-1:0] len;
  logic [PosW-1:0] p;
  logic [PosW:0]   end_pos;
  res_t            res;

  assign in_ch.ready = !sv_q;
  assign accept      = in_ch.valid && in_ch.ready;
  assign active      = accept && !stopped_q;
  assign pop         = ov_q && out_ch.ready;

  always_comb begin
    for (int i = 0; i < HdrBytes - 1; i++) begin
      nw[i] = win_q[i+1];
    end
    nw[HdrBytes-1] = in_ch.data_byte;
  end

  // leading magics
  assign cdf  = (pos_q == PosW'(2)) && nw[13] == ChC && nw[14] == ChD && nw[15] == ChF;
  assign fmig = (pos_q == PosW'(3)) && nw[12] == ChF && nw[13] == ChM &&
                nw[14] == ChI && nw[15] == ChG;
  assign qd   = (pos_q == PosW'(4)) &&
                {nw[11], nw[12], nw[13], nw[14], nw[15]} == QdMagic;
  assign magic_done = cdf || fmig || qd;

  // candidate at p = pos - 15
  assign cand_en = !magic_done && pos_q >= LastHdrAt && pos_q != PosMax;
  assign p       = pos_q - LastHdrAt;
  assign grib    = nw[0] == ChG && nw[1] == ChR && nw[2] == ChI && nw[3] == ChB;
  assign ed      = nw[7];
  assign ed_ok   = ed == Ed1 || ed == Ed2;

  always_comb begin
    if (ed == Ed1) begin
      len = {40'd0, nw[4], nw[5], nw[6]};
    end else if (ed == Ed2) begin
      len = {nw[8], nw[9], nw[10], nw[11], nw[12], nw[13], nw[14], nw[15]};
    end else begin
      len = '0;
    end
  end

  assign end_pos = {1'b0, p} + {1'b0, len[PosW-1:0]};
  assign hit = cand_en && p >= resume_q && grib && ed_ok &&
               len[LenW-1:PosW] == '0 && len[PosW-1:0] >= MinLen &&
               end_pos <= {1'b0, ds_q};
  assign cnt_inc = cnt_q + CntW'(1);

  always_comb begin
    res.found    = cdf || qd || hit;
    res.done_res = magic_done || (hit && cnt_inc >= max_q) || in_ch.last_byte;
    res.offset   = hit ? p : '0;
    priority if (cdf) begin
      res.kind = KIND_NETCDF;
    end else if (qd) begin
      res.kind = KIND_QUERYDATA;
    end else if (hit && ed == Ed2) begin
      res.kind = KIND_GRIB2;
    end else begin
      res.kind = KIND_GRIB1;
    end
  end

  assign push = active && (res.found || res.done_res);

  always_comb begin
    pos_d     = pos_q;
    resume_d  = resume_q;
    cnt_d     = cnt_q;
    stopped_d = stopped_q;
    if (active) begin
      if (pos_q != PosMax) begin
        pos_d = pos_q + PosW'(1);
      end
      if (hit) begin
        resume_d = end_pos[PosW-1:0];
        cnt_d    = cnt_inc;
      end
      if (res.done_res) begin
        stopped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HdrBytes; i++) begin
        win_q[i] <= '0;
      end
      pos_q     <= '0;
      resume_q  <= '0;
      cnt_q     <= '0;
      stopped_q <= 1'b0;
    end else begin
      if (active) begin
        for (int i = 0; i < HdrBytes; i++) begin
          win_q[i] <= nw[i];
        end
      end
      pos_q     <= pos_d;
      resume_q  <= resume_d;
      cnt_q     <= cnt_d;
      stopped_q <= stopped_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ds_q  <= '0;
      max_q <= MaxMsgRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgDataSize) begin
        ds_q <= cfg_wdata_i[PosW-1:0];
      end else if (cfg_idx_i == CfgMaxMessages) begin
        max_q <= cfg_wdata_i[CntW-1:0];
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (pop) begin
        if (sv_q) begin
          sv_q <= 1'b0;
        end else begin
          ov_q <= push;
        end
      end else if (push) begin
        if (!ov_q) begin
          ov_q <= 1'b1;
        end else begin
          sv_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && sv_q) begin
      od_q <= sd_q;
    end else if (push && (pop || !ov_q)) begin
      od_q <= res;
    end
    if (push && ov_q && !pop) begin
      sd_q <= res;
    end
  end

  assign out_ch.valid    = ov_q;
  assign out_ch.found    = od_q.found;
  assign out_ch.kind     = od_q.kind;
  assign out_ch.offset   = od_q.offset;
  assign out_ch.done_res = od_q.done_res;

  `GML_ASSERT_IMP(a_skid_behind_out, sv_q, ov_q, "skid entry held without output entry")
  `GML_ASSERT_NXT(a_stop_sticks, stopped_q, stopped_q, "scan restarted without reset")
  `GML_ASSERT_NXT(a_done_stops, push && res.done_res, stopped_q, "finishing beat did not stop")
  `GML_ASSERT_IMP(a_magic_finishes, push && (cdf || qd), res.done_res,
                  "format record without finish")
  `GML_ASSERT_NXT(a_no_push_stopped, stopped_q && !pop && !sv_q, ov_q == $past(ov_q),
                  "result produced after stop")

endmodule

`default_nettype wire

FILE: tb/grib_message_locator_core_checker.sv
`timescale 1ns / 1ps
// result checker for the grib message locator: watches the config port and both channels,
// predicts each result from the byte stream and compares it field by field
// depends on gml_pkg, gml_in_if and gml_out_if
module grib_message_locator_core_checker
  import gml_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  gml_in_if                   in_ch,
  gml_out_if                  out_ch,
  output int                  fails_o,
  output int                  pending_o,
  output int                  records_o
);

  logic [PosW-1:0]         file_size;
  logic [CntW-1:0]         msg_limit;
  logic [HdrBytes*8-1:0]   hdr_win;
  logic [PosW-1:0]         byte_pos;
  logic [PosW-1:0]         resume_pos;
  logic [CntW-1:0]         msg_count;
  logic                    halted;
  res_t                    due_results[$];
  res_t                    want;

  task automatic check_field(input string name, input logic [PosW-1:0] want_v,
                             input logic [PosW-1:0] got_v);
    if (want_v !== got_v) begin
      fails_o++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want_v, got_v);
    end
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    logic [PosW-1:0] p;
    logic [LenW-1:0] len;
    logic [7:0]      ed;
    res_t            r;
    r = '0;
    if (halted) return;
    hdr_win = {hdr_win[HdrBytes*8-9:0], b};
    // leading magics, judged once their last byte is in
    if (byte_pos == PosW'(2) && hdr_win[23:0] == {ChC, ChD, ChF}) begin
      r.found = 1'b1;
      r.kind = KIND_NETCDF;
      r.done_res = 1'b1;
    end else if (byte_pos == PosW'(3) && hdr_win[31:0] == {ChF, ChM, ChI, ChG}) begin
      r.done_res = 1'b1;
    end else if (byte_pos == PosW'(4) && hdr_win[39:0] == QdMagic) begin
      r.found = 1'b1;
      r.kind = KIND_QUERYDATA;
      r.done_res = 1'b1;
    end
    if (!r.done_res && byte_pos >= LastHdrAt && byte_pos != PosMax) begin
      p = byte_pos - LastHdrAt;
      ed = hdr_win[71:64];
      len = (ed == Ed1) ? LenW'(hdr_win[95:72]) : hdr_win[63:0];
      if (p >= resume_pos && hdr_win[127:96] == {ChG, ChR, ChI, ChB} &&
          (ed == Ed1 || ed == Ed2) && len >= LenW'(MinLen) &&
          len <= LenW'(file_size) && LenW'(p) <= LenW'(file_size) - len) begin
        r.found = 1'b1;
        r.kind = (ed == Ed1) ? KIND_GRIB1 : KIND_GRIB2;
        r.offset = p;
        resume_pos = p + len[PosW-1:0];
        msg_count = msg_count + 1'b1;
        if (msg_count >= msg_limit) r.done_res = 1'b1;
      end
    end
    if (byte_pos != PosMax) byte_pos = byte_pos + 1'b1;
    if (last) r.done_res = 1'b1;
    if (r.found || r.done_res) begin
      due_results.push_back(r);
      halted = r.done_res;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size = '0;
      msg_limit = MaxMsgRst;
      hdr_win = '0;
      byte_pos = '0;
      resume_pos = '0;
      msg_count = '0;
      halted = 1'b0;
      due_results.delete();
      fails_o = 0;
      records_o = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_results.size() == 0) begin
          fails_o++;
          $display("%0t: result with none due: found %0b kind %0d offset %0h done %0b",
                   $time, out_ch.found, out_ch.kind, out_ch.offset, out_ch.done_res);
        end else begin
          want = due_results.pop_front();
          check_field("found", PosW'(want.found), PosW'(out_ch.found));
          check_field("kind", PosW'(want.kind), PosW'(out_ch.kind));
          check_field("offset", want.offset, out_ch.offset);
          check_field("done_res", PosW'(want.done_res), PosW'(out_ch.done_res));
          if (want.found) records_o++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgDataSize:    file_size = cfg_wdata_i[PosW-1:0];
          CfgMaxMessages: msg_limit = cfg_wdata_i[CntW-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) scan_byte(in_ch.data_byte, in_ch.last_byte);
    end
    pending_o = due_results.size();
  end

endmodule

FILE: tb/grib_message_locator_core_tb.sv
`timescale 1ns / 1ps
// testbench top for the grib message locator: clock, reset, config writes, byte stream
// and verdict; depends on gml_pkg, both channel interfaces, the core and its checker
module grib_message_locator_core_tb;
  import gml_pkg::*;

  localparam int Items      = 1400;
  localparam int MinRecords = 48;
  localparam int Limit      = 300000;
  localparam int HoldCycles = 150;

  localparam logic [CfgIdxW-1:0] CfgSpareA = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = CfgDataSize;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  gml_in_if  in_ch();
  gml_out_if out_ch();

  int fails;
  int pending;
  int records;
  int src_idle_pct;
  int snk_stall_pct;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;
  int sent = 0;
  int phase;

  logic [PosW-1:0] file_pos = '0;
  beat_t           file_q[$];

  grib_message_locator_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  grib_message_locator_core_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fails_o    (fails),
    .pending_o  (pending),
    .records_o  (records)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic set_mode(input int m);
    case (m)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 81; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 81; end
      default: begin src_idle_pct = 36; snk_stall_pct = 36; end
    endcase
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic put_byte(input logic [7:0] b);
    file_q.push_back('{data: b, last: 1'b0});
    file_pos = file_pos + 1'b1;
  endtask

  task automatic put_noise(input int n);
    repeat (n) put_byte(8'($urandom));
  endtask

  task automatic put_header(input logic [7:0] ed, input logic [LenW-1:0] len);
    logic [HdrBytes*8-1:0] hdr;
    hdr = {ChG, ChR, ChI, ChB, 24'($urandom), ed, 32'($urandom), 32'($urandom)};
    if (ed == Ed1) hdr[95:72] = len[23:0];
    else if (ed == Ed2) hdr[63:0] = len;
    for (int i = HdrBytes - 1; i >= 0; i--) put_byte(hdr[i*8 +: 8]);
  endtask

  task automatic put_message(input logic [7:0] ed, input int len);
    int rest;
    put_header(ed, LenW'(len));
    rest = len - 16;
    // header hidden in the body, to be skipped
    if (rest >= 16 && $urandom_range(4) == 0) begin
      put_header(Ed1, LenW'(16));
      rest -= 16;
    end
    put_noise(rest);
  endtask

  task automatic put_broken();
    logic [7:0] ed;
    case ($urandom_range(3))
      0: begin
        do ed = 8'($urandom); while (ed == Ed1 || ed == Ed2);
        put_header(ed, LenW'($urandom_range(16, 40)));
      end
      1: put_header($urandom_range(1) ? Ed1 : Ed2, LenW'($urandom_range(15)));
      2: put_header(Ed2, {16'($urandom) | 16'h1, 16'($urandom), 32'($urandom)});
      default: begin
        put_byte(ChG);
        put_byte(ChR);
        put_byte(ChI);
      end
    endcase
    put_noise($urandom_range(4));
  endtask

  task automatic put_stream(input int n);
    logic [PosW-1:0] start;
    int              r;
    start = file_pos;
    while (file_pos - start < PosW'(n)) begin
      r = $urandom_range(99);
      if (r < 55)
        put_message($urandom_range(1) ? Ed1 : Ed2,
                    ($urandom_range(9) == 0) ? $urandom_range(41, 200) : $urandom_range(16, 40));
      else if (r < 75)
        put_broken();
      else
        put_noise($urandom_range(1, 8));
    end
  endtask

  task automatic send_file();
    beat_t bt;
    while (file_q.size() != 0) begin
      bt = file_q.pop_front();
      while ($urandom_range(99) < src_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
      in_ch.valid <= 1'b1;
      in_ch.data_byte <= bt.data;
      in_ch.last_byte <= bt.last;
      @(posedge clk_i);
      while (!in_ch.ready) @(posedge clk_i);
      @(negedge clk_i);
      sent++;
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    logic [39:0] lead;
    int          len;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready = 1'b0;
    set_mode(0);
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    cfg_write(CfgDataSize, CfgDataW'(PosMax));
    cfg_write(CfgMaxMessages, {16'($urandom), MaxMsgRst});
    cfg_write(CfgSpareA, {16'($urandom), 32'($urandom)});
    cfg_write(CfgSpareB, '0);

    // a full magic would end the scan for good, so the file opens on a near miss
    case ($urandom_range(2))
      0: lead = {ChC, ChD, 8'h00, 8'hFF, 8'h00};
      1: lead = {ChF, ChM, ChI, 8'hFF, 8'h00};
      default: lead = {QdMagic[39:8], 8'h50};
    endcase
    for (int i = 4; i >= 0; i--) put_byte(lead[i*8 +: 8]);
    put_message(Ed1, 16);
    send_file();
    drain();

    phase = 0;
    while ((sent < Items || records < MinRecords) && phase < 64) begin
      set_mode(phase % 4);
      case (phase)
        1: cfg_write(CfgDataSize, '0);
        2: begin
          // first message ends exactly at the file size, the next one overruns it
          len = $urandom_range(16, 40);
          cfg_write(CfgDataSize, CfgDataW'(file_pos + PosW'(len)));
          put_message($urandom_range(1) ? Ed1 : Ed2, len);
          put_message(Ed1, 16);
        end
        default: cfg_write(CfgDataSize, (phase % 2 != 0) ? CfgDataW'(PosMax) :
                           {16'($urandom) | 16'h1, 32'($urandom)});
      endcase
      if (phase % 3 == 0)
        cfg_write(CfgMaxMessages, {16'($urandom), 32'($urandom) | 32'h0010_0000});
      if (phase == 3) begin
        src_idle_pct = 0;
        hold_req++;
        repeat (24) put_message($urandom_range(1) ? Ed1 : Ed2, 16);
      end
      put_stream(140);
      send_file();
      drain();
      phase++;
    end

    // closing header: huge edition 2 length, message limit of zero or one, last byte
    set_mode($urandom_range(3));
    cfg_write(CfgDataSize, CfgDataW'(PosMax));
    cfg_write(CfgMaxMessages, CfgDataW'($urandom_range(1)));
    put_noise(3);
    put_header(Ed2, {24'd0, 8'($urandom) | 8'h01, 32'($urandom)});
    file_q[file_q.size() - 1].last = 1'b1;
    send_file();
    drain();
    repeat (8) @(negedge clk_i);

    $display("scanned %0d file bytes in %0d phases of idle and stall patterns", sent, phase + 2);
    $display("%0d records located; near-miss magic, size limits, output hold-off, limit stop",
             records);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
